### sv/acpi_tsp_pkg.sv
// Shared types and constants for the ACPI table stream parser.
package acpi_tsp_pkg;

  localparam logic [1:0] OP_TABLE_BYTE = 2'd0;
  localparam logic [1:0] OP_READ_CPU   = 2'd1;
  localparam logic [1:0] OP_READ_IOAPIC = 2'd2;
  localparam logic [1:0] OP_READ_OVR   = 2'd3;

  localparam logic [1:0] RSP_TABLE_DONE = 2'd0;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_APIC  = 2'd1;
  localparam logic [1:0] KIND_HPET  = 2'd2;

  localparam logic [7:0] ENT_LAPIC     = 8'd0;
  localparam logic [7:0] ENT_IOAPIC    = 8'd1;
  localparam logic [7:0] ENT_OVERRIDE  = 8'd2;
  localparam logic [7:0] ENT_LAPIC_OVR = 8'd5;

  localparam logic [31:0] HDR_LEN      = 32'd36;
  localparam logic [31:0] ENTRY_BASE   = 32'd44;
  localparam logic [31:0] HPET_MIN_LEN = 32'd52;
  localparam logic [31:0] MADT_LAPIC_LEN = 32'd40;
  localparam logic [31:0] SIG_APIC     = 32'h4349_5041;
  localparam logic [31:0] SIG_HPET     = 32'h5445_5048;
  localparam int          ENTRY_BUF    = 12;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       first_byte;
    logic [5:0] index;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  response_kind;
    logic        table_valid;
    logic [1:0]  table_kind;
    logic [63:0] lapic_address;
    logic [63:0] hpet_base;
    logic [6:0]  cpu_total;
    logic [4:0]  io_apic_total;
    logic [4:0]  override_total;
    logic [15:0] valid_tables;
    logic [7:0]  entry_id;
    logic [31:0] entry_word_a;
    logic [31:0] entry_word_b;
  } out_rsp_t;

  // store write port: id/address/gsi for I/O APIC, source/gsi/flags for override
  typedef struct packed {
    logic        cpu_we;
    logic [7:0]  cpu_addr;
    logic [7:0]  cpu_data;
    logic        io_we;
    logic [7:0]  io_addr;
    logic [71:0] io_data;
    logic        ov_we;
    logic [7:0]  ov_addr;
    logic [55:0] ov_data;
  } store_wr_t;

  typedef struct packed {
    logic [7:0]  cpu_data;
    logic [71:0] io_data;
    logic [55:0] ov_data;
  } store_rd_t;

endpackage

### sv/acpi_tsp_store.sv
// Entry stores for CPU APIC ids, I/O APIC records and source overrides.
module acpi_tsp_store import acpi_tsp_pkg::*; #(
  parameter int MAX_CPUS      = 64,
  parameter int MAX_IO_APICS  = 16,
  parameter int MAX_OVERRIDES = 16
) (
  input  logic      clk,
  input  logic      rd_en,
  input  logic [5:0] rd_index,
  input  store_wr_t wr,
  output store_rd_t rd
);

  localparam int CAW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int IAW = (MAX_IO_APICS > 1) ? $clog2(MAX_IO_APICS) : 1;
  localparam int OAW = (MAX_OVERRIDES > 1) ? $clog2(MAX_OVERRIDES) : 1;

  logic [7:0]  cpu_mem [MAX_CPUS];
  logic [71:0] io_mem  [MAX_IO_APICS];
  logic [55:0] ov_mem  [MAX_OVERRIDES];

  logic [CAW-1:0] cpu_wa, cpu_ra;
  logic [IAW-1:0] io_wa, io_ra;
  logic [OAW-1:0] ov_wa, ov_ra;
  store_rd_t rd_r;

  assign cpu_wa = CAW'(wr.cpu_addr);
  assign io_wa  = IAW'(wr.io_addr);
  assign ov_wa  = OAW'(wr.ov_addr);
  assign cpu_ra = CAW'(rd_index);
  assign io_ra  = IAW'(rd_index);
  assign ov_ra  = OAW'(rd_index);
  assign rd     = rd_r;

  always_ff @(posedge clk) begin
    if (wr.cpu_we) cpu_mem[cpu_wa] <= wr.cpu_data;
    if (wr.io_we) io_mem[io_wa] <= wr.io_data;
    if (wr.ov_we) ov_mem[ov_wa] <= wr.ov_data;
  end

  // new data wins on a same-cycle write to the read address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r.cpu_data <= (wr.cpu_we && cpu_wa == cpu_ra) ? wr.cpu_data : cpu_mem[cpu_ra];
      rd_r.io_data  <= (wr.io_we && io_wa == io_ra) ? wr.io_data : io_mem[io_ra];
      rd_r.ov_data  <= (wr.ov_we && ov_wa == ov_ra) ? wr.ov_data : ov_mem[ov_ra];
    end
  end

endmodule

### sv/acpi_tsp_core.sv
// Table byte decode, checksum, commit logic and read response formatting.
module acpi_tsp_core import acpi_tsp_pkg::*; #(
  parameter int MAX_CPUS      = 64,
  parameter int MAX_IO_APICS  = 16,
  parameter int MAX_OVERRIDES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_req_t   req,
  input  store_rd_t rd,
  output store_wr_t wr,
  output out_rsp_t  rsp,
  output logic      rsp_vld
);

  localparam int CPW = $clog2(MAX_CPUS + 1);
  localparam int IOW = $clog2(MAX_IO_APICS + 1);
  localparam int OVW = $clog2(MAX_OVERRIDES + 1);

  logic        active_r, active_nxt;
  logic [31:0] off_r, off_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] sig_r, sig_nxt;
  logic [31:0] estart_r, estart_nxt;
  logic        stopped_r, stopped_nxt;
  logic [7:0]  ent_r [ENTRY_BUF];
  logic [7:0]  ent_nxt [ENTRY_BUF];
  logic [63:0] plapic_r, plapic_nxt, phpet_r, phpet_nxt;
  logic [63:0] clapic_r, clapic_nxt, chpet_r, chpet_nxt;
  logic [CPW-1:0] pcpu_r, pcpu_nxt, ccpu_r, ccpu_nxt;
  logic [IOW-1:0] pio_r, pio_nxt, cio_r, cio_nxt;
  logic [OVW-1:0] pov_r, pov_nxt, cov_r, cov_nxt;
  logic [15:0] good_r, good_nxt;

  logic [7:0]  b;
  logic [31:0] off, rel, elen;
  logic [7:0]  em [ENTRY_BUF];
  logic        done, ok;
  logic [1:0]  kind;

  always_comb begin
    active_nxt  = active_r;
    off_nxt     = off_r;
    sum_nxt     = sum_r;
    len_nxt     = len_r;
    sig_nxt     = sig_r;
    estart_nxt  = estart_r;
    stopped_nxt = stopped_r;
    ent_nxt     = ent_r;
    plapic_nxt  = plapic_r;
    phpet_nxt   = phpet_r;
    clapic_nxt  = clapic_r;
    chpet_nxt   = chpet_r;
    pcpu_nxt    = pcpu_r;
    pio_nxt     = pio_r;
    pov_nxt     = pov_r;
    ccpu_nxt    = ccpu_r;
    cio_nxt     = cio_r;
    cov_nxt     = cov_r;
    good_nxt    = good_r;
    wr          = '0;
    rsp         = '0;
    rsp_vld     = 1'b0;
    done        = 1'b0;
    ok          = 1'b0;
    kind        = KIND_OTHER;
    b           = req.data_byte;
    off         = '0;
    rel         = '0;
    elen        = '0;
    em          = ent_r;

    if (req.opcode == OP_TABLE_BYTE) begin
      if (req.first_byte) begin
        off_nxt     = '0;
        sum_nxt     = '0;
        len_nxt     = '0;
        sig_nxt     = '0;
        active_nxt  = 1'b1;
        estart_nxt  = ENTRY_BASE;
        stopped_nxt = 1'b0;
        plapic_nxt  = clapic_r;
        phpet_nxt   = chpet_r;
        pcpu_nxt    = ccpu_r;
        pio_nxt     = cio_r;
        pov_nxt     = cov_r;
      end
      if (active_nxt) begin
        off     = off_nxt;
        sum_nxt = sum_nxt + b;
        if (off < 32'd4) begin
          sig_nxt = sig_nxt | (32'(b) << {off[1:0], 3'b000});
        end else if (off < 32'd8) begin
          len_nxt = len_nxt | (32'(b) << {off[1:0], 3'b000});
          if (off == 32'd7 && len_nxt < HDR_LEN) begin
            active_nxt = 1'b0;
            done       = 1'b1;
            rsp_vld    = 1'b1;
          end
        end else if (sig_nxt == SIG_APIC) begin
          if (off >= HDR_LEN && off < MADT_LAPIC_LEN && len_nxt >= MADT_LAPIC_LEN) begin
            if (off == HDR_LEN) plapic_nxt = 64'(b);
            else plapic_nxt = plapic_nxt | (64'(b) << {off[1:0], 3'b000});
          end else if (off >= ENTRY_BASE && !stopped_nxt) begin
            rel = off - estart_nxt;
            for (int i = 0; i < ENTRY_BUF; i++) begin
              if (rel == 32'(i)) em[i] = b;
            end
            if (rel < 32'(ENTRY_BUF)) ent_nxt = em;
            if (rel >= 32'd1) begin
              elen = 32'(em[1]);
              if (elen < 32'd2) begin
                stopped_nxt = 1'b1;
              end else if (rel == elen - 32'd1) begin
                estart_nxt = off + 32'd1;
                unique case (em[0])
                  ENT_LAPIC: begin
                    if (elen >= 32'd8 && em[4][0] && pcpu_nxt < CPW'(MAX_CPUS)) begin
                      wr.cpu_we   = 1'b1;
                      wr.cpu_addr = 8'(pcpu_nxt);
                      wr.cpu_data = em[3];
                      pcpu_nxt    = pcpu_nxt + 1'b1;
                    end
                  end
                  ENT_IOAPIC: begin
                    if (elen >= 32'd12 && pio_nxt < IOW'(MAX_IO_APICS)) begin
                      wr.io_we   = 1'b1;
                      wr.io_addr = 8'(pio_nxt);
                      wr.io_data = {em[2], em[7], em[6], em[5], em[4],
                                    em[11], em[10], em[9], em[8]};
                      pio_nxt    = pio_nxt + 1'b1;
                    end
                  end
                  ENT_OVERRIDE: begin
                    if (elen >= 32'd10 && pov_nxt < OVW'(MAX_OVERRIDES)) begin
                      wr.ov_we   = 1'b1;
                      wr.ov_addr = 8'(pov_nxt);
                      wr.ov_data = {em[3], em[7], em[6], em[5], em[4], em[9], em[8]};
                      pov_nxt    = pov_nxt + 1'b1;
                    end
                  end
                  ENT_LAPIC_OVR: begin
                    if (elen >= 32'd12)
                      plapic_nxt = {em[11], em[10], em[9], em[8],
                                    em[7], em[6], em[5], em[4]};
                  end
                  default: begin
                  end
                endcase
              end
            end
          end
        end else if (sig_nxt == SIG_HPET) begin
          if (off >= ENTRY_BASE && off < HPET_MIN_LEN && len_nxt >= HPET_MIN_LEN) begin
            // byte lane is off - 44; the low three bits of that are off[2:0] with bit 2 flipped
            if (off == ENTRY_BASE) phpet_nxt = 64'(b);
            else phpet_nxt = phpet_nxt | (64'(b) << {~off[2], off[1:0], 3'b000});
          end
        end

        kind = (sig_nxt == SIG_APIC) ? KIND_APIC :
               (sig_nxt == SIG_HPET) ? KIND_HPET : KIND_OTHER;

        if (!done) begin
          if (off >= HDR_LEN - 32'd1 && off == len_nxt - 32'd1) begin
            ok         = (sum_nxt == 8'd0);
            active_nxt = 1'b0;
            rsp_vld    = 1'b1;
            if (ok) begin
              if (good_nxt != 16'hFFFF) good_nxt = good_nxt + 16'd1;
              if (kind == KIND_APIC) begin
                clapic_nxt = plapic_nxt;
                ccpu_nxt   = pcpu_nxt;
                cio_nxt    = pio_nxt;
                cov_nxt    = pov_nxt;
              end else if (kind == KIND_HPET) begin
                chpet_nxt = phpet_nxt;
              end
            end
          end else begin
            off_nxt = off + 32'd1;
          end
        end
      end
      rsp.response_kind = RSP_TABLE_DONE;
      rsp.table_valid   = ok;
      rsp.table_kind    = kind;
    end else begin
      rsp_vld           = 1'b1;
      rsp.response_kind = req.opcode;
      unique case (req.opcode)
        OP_READ_CPU: begin
          if (32'(req.index) < 32'(ccpu_r) && 32'(req.index) < 32'(MAX_CPUS))
            rsp.entry_id = rd.cpu_data;
        end
        OP_READ_IOAPIC: begin
          if (32'(req.index) < 32'(cio_r) && 32'(req.index) < 32'(MAX_IO_APICS)) begin
            rsp.entry_id     = rd.io_data[71:64];
            rsp.entry_word_a = rd.io_data[63:32];
            rsp.entry_word_b = rd.io_data[31:0];
          end
        end
        OP_READ_OVR: begin
          if (32'(req.index) < 32'(cov_r) && 32'(req.index) < 32'(MAX_OVERRIDES)) begin
            rsp.entry_id     = rd.ov_data[55:48];
            rsp.entry_word_a = rd.ov_data[47:16];
            rsp.entry_word_b = 32'(rd.ov_data[15:0]);
          end
        end
        default: begin
        end
      endcase
    end

    rsp.lapic_address  = clapic_nxt;
    rsp.hpet_base      = chpet_nxt;
    rsp.cpu_total      = 7'(ccpu_nxt);
    rsp.io_apic_total  = 5'(cio_nxt);
    rsp.override_total = 5'(cov_nxt);
    rsp.valid_tables   = good_nxt;

    if (!step) begin
      wr      = '0;
      rsp_vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      off_r     <= '0;
      sum_r     <= '0;
      len_r     <= '0;
      sig_r     <= '0;
      estart_r  <= ENTRY_BASE;
      stopped_r <= 1'b0;
      plapic_r  <= '0;
      phpet_r   <= '0;
      clapic_r  <= '0;
      chpet_r   <= '0;
      pcpu_r    <= '0;
      pio_r     <= '0;
      pov_r     <= '0;
      ccpu_r    <= '0;
      cio_r     <= '0;
      cov_r     <= '0;
      good_r    <= '0;
    end else if (step) begin
      active_r  <= active_nxt;
      off_r     <= off_nxt;
      sum_r     <= sum_nxt;
      len_r     <= len_nxt;
      sig_r     <= sig_nxt;
      estart_r  <= estart_nxt;
      stopped_r <= stopped_nxt;
      plapic_r  <= plapic_nxt;
      phpet_r   <= phpet_nxt;
      clapic_r  <= clapic_nxt;
      chpet_r   <= chpet_nxt;
      pcpu_r    <= pcpu_nxt;
      pio_r     <= pio_nxt;
      pov_r     <= pov_nxt;
      ccpu_r    <= ccpu_nxt;
      cio_r     <= cio_nxt;
      cov_r     <= cov_nxt;
      good_r    <= good_nxt;
    end
  end

  // entry byte buffer carries no reset
  always_ff @(posedge clk) begin
    if (step) ent_r <= ent_nxt;
  end

endmodule

### sv/acpi_table_stream_parser.sv
// ACPI table stream parser top level: request register, decode core, result register.
// The store read port is read at accept time, when the request is registered.
// Throughput: one request per cycle while in_stall is low.
// in_stall is high only while a result is held and out_stall is high.
// Reset (rst_n low, synchronous) clears control, counts and addresses;
// entry stores are not cleared and are only read below the committed counts.
module acpi_table_stream_parser import acpi_tsp_pkg::*; #(
  parameter int MAX_CPUS      = 64,
  parameter int MAX_IO_APICS  = 16,
  parameter int MAX_OVERRIDES = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_rsp
);

  logic      adv;
  logic      s1_valid_r;
  in_req_t   s1_req_r;
  logic      out_valid_r;
  out_rsp_t  out_rsp_r;
  store_wr_t wr;
  store_rd_t rd;
  out_rsp_t  rsp;
  logic      rsp_vld;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_valid;
      out_valid_r <= rsp_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_req_r  <= in_req;
      out_rsp_r <= rsp;
    end
  end

  acpi_tsp_store #(
    .MAX_CPUS      (MAX_CPUS),
    .MAX_IO_APICS  (MAX_IO_APICS),
    .MAX_OVERRIDES (MAX_OVERRIDES)
  ) u_store (
    .clk      (clk),
    .rd_en    (adv),
    .rd_index (in_req.index),
    .wr       (wr),
    .rd       (rd)
  );

  acpi_tsp_core #(
    .MAX_CPUS      (MAX_CPUS),
    .MAX_IO_APICS  (MAX_IO_APICS),
    .MAX_OVERRIDES (MAX_OVERRIDES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv && s1_valid_r),
    .req     (s1_req_r),
    .rd      (rd),
    .wr      (wr),
    .rsp     (rsp),
    .rsp_vld (rsp_vld)
  );

endmodule

### dv/tb.sv
// Testbench for the ACPI table stream parser: directed and random table streams with a scoreboard.
`timescale 1ns / 1ps
module tb;
  import acpi_tsp_pkg::*;

  localparam int N_CPU = 64;
  localparam int N_IO  = 16;
  localparam int N_OVR = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  // Scoreboard: mirrors the parser state and queues the predicted responses.
  class parser_scoreboard;
    bit [31:0] offset, tlen, tsig, ent_start;
    bit [7:0]  csum;
    bit        active, stopped;
    bit [7:0]  ebuf[12];
    bit [63:0] p_lapic, p_hpet, c_lapic, c_hpet;
    int unsigned p_cnt[3], c_cnt[3];
    bit [15:0] good;
    bit [7:0]  cpu_ids[N_CPU];
    bit [71:0] io_recs[N_IO];
    bit [55:0] ovr_recs[N_OVR];
    out_rsp_t  pending_rsp[$];
    int        errors;
    int        tables_done, reads_done;

    function new();
      errors = 0;
      tables_done = 0;
      reads_done = 0;
      ent_start = ENTRY_BASE;
      foreach (ebuf[i]) ebuf[i] = 0;
    endfunction

    function bit [1:0] kind_now();
      if (tsig == SIG_APIC) return KIND_APIC;
      if (tsig == SIG_HPET) return KIND_HPET;
      return KIND_OTHER;
    endfunction

    function out_rsp_t common(bit [1:0] rk);
      out_rsp_t r;
      r = '0;
      r.response_kind = rk;
      r.lapic_address = c_lapic;
      r.hpet_base = c_hpet;
      r.cpu_total = c_cnt[0][6:0];
      r.io_apic_total = c_cnt[1][4:0];
      r.override_total = c_cnt[2][4:0];
      r.valid_tables = good;
      return r;
    endfunction

    function bit [31:0] word_at(int p);
      return {ebuf[p+3], ebuf[p+2], ebuf[p+1], ebuf[p]};
    endfunction

    function void decode_entry(int unsigned len);
      case (ebuf[0])
        ENT_LAPIC:
          if (len >= 8 && ebuf[4][0] && p_cnt[0] < N_CPU) begin
            cpu_ids[p_cnt[0]] = ebuf[3];
            p_cnt[0]++;
          end
        ENT_IOAPIC:
          if (len >= 12 && p_cnt[1] < N_IO) begin
            io_recs[p_cnt[1]] = {ebuf[2], word_at(4), word_at(8)};
            p_cnt[1]++;
          end
        ENT_OVERRIDE:
          if (len >= 10 && p_cnt[2] < N_OVR) begin
            ovr_recs[p_cnt[2]] = {ebuf[3], word_at(4), ebuf[9], ebuf[8]};
            p_cnt[2]++;
          end
        ENT_LAPIC_OVR:
          if (len >= 12) p_lapic = {word_at(8), word_at(4)};
        default: ;
      endcase
    endfunction

    function void table_byte(bit [7:0] b, bit first);
      out_rsp_t r;
      bit [31:0] off, rel;
      bit ok;
      if (first) begin
        offset = 0; csum = 0; tlen = 0; tsig = 0; active = 1;
        ent_start = ENTRY_BASE; stopped = 0;
        p_lapic = c_lapic; p_hpet = c_hpet; p_cnt = c_cnt;
      end
      if (!active) return;
      off = offset;
      csum = csum + b;
      if (off < 4) begin
        tsig |= 32'(b) << (8 * off);
      end else if (off < 8) begin
        tlen |= 32'(b) << (8 * (off - 4));
        if (off == 7 && tlen < HDR_LEN) begin
          active = 0;
          r = common(RSP_TABLE_DONE);
          r.table_kind = kind_now();
          pending_rsp.push_back(r);
          tables_done++;
          return;
        end
      end else if (tsig == SIG_APIC) begin
        if (off >= 36 && off < 40 && tlen >= MADT_LAPIC_LEN) begin
          if (off == 36) p_lapic = 64'(b);
          else p_lapic |= 64'(b) << (8 * (off - 36));
        end else if (off >= ENTRY_BASE && !stopped) begin
          rel = off - ent_start;
          if (rel < 12) ebuf[rel] = b;
          if (rel >= 1) begin
            if (ebuf[1] < 2) stopped = 1;
            else if (rel == 32'(ebuf[1]) - 1) begin
              decode_entry(ebuf[1]);
              ent_start = off + 1;
            end
          end
        end
      end else if (tsig == SIG_HPET) begin
        if (off >= ENTRY_BASE && off < HPET_MIN_LEN && tlen >= HPET_MIN_LEN) begin
          if (off == ENTRY_BASE) p_hpet = 64'(b);
          else p_hpet |= 64'(b) << (8 * (off - ENTRY_BASE));
        end
      end
      if (off >= HDR_LEN - 1 && off == tlen - 1) begin
        ok = (csum == 0);
        active = 0;
        if (ok) begin
          if (good != 16'hFFFF) good++;
          if (kind_now() == KIND_APIC) begin
            c_lapic = p_lapic;
            c_cnt = p_cnt;
          end else if (kind_now() == KIND_HPET) begin
            c_hpet = p_hpet;
          end
        end
        r = common(RSP_TABLE_DONE);
        r.table_valid = ok;
        r.table_kind = kind_now();
        pending_rsp.push_back(r);
        tables_done++;
        return;
      end
      offset = off + 1;
    endfunction

    function void note_request(in_req_t q);
      out_rsp_t r;
      if (q.opcode == OP_TABLE_BYTE) begin
        table_byte(q.data_byte, q.first_byte);
        return;
      end
      r = common(q.opcode);
      if (q.opcode == OP_READ_CPU) begin
        if (q.index < c_cnt[0]) r.entry_id = cpu_ids[q.index];
      end else if (q.opcode == OP_READ_IOAPIC) begin
        if (q.index < c_cnt[1])
          {r.entry_id, r.entry_word_a, r.entry_word_b} = io_recs[q.index];
      end else begin
        if (q.index < c_cnt[2])
          {r.entry_id, r.entry_word_a, r.entry_word_b} = {ovr_recs[q.index][55:16],
                                                          16'h0, ovr_recs[q.index][15:0]};
      end
      pending_rsp.push_back(r);
      reads_done++;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
    endtask

    task check_response(out_rsp_t g);
      out_rsp_t w;
      if (pending_rsp.size() == 0) begin
        report("unexpected response", g.response_kind, 0);
        return;
      end
      w = pending_rsp.pop_front();
      if (g.response_kind !== w.response_kind)
        report("response_kind", g.response_kind, w.response_kind);
      if (g.table_valid !== w.table_valid)
        report("table_valid", g.table_valid, w.table_valid);
      if (g.table_kind !== w.table_kind)
        report("table_kind", g.table_kind, w.table_kind);
      if (g.lapic_address !== w.lapic_address)
        report("lapic_address", g.lapic_address, w.lapic_address);
      if (g.hpet_base !== w.hpet_base)
        report("hpet_base", g.hpet_base, w.hpet_base);
      if (g.cpu_total !== w.cpu_total)
        report("cpu_total", g.cpu_total, w.cpu_total);
      if (g.io_apic_total !== w.io_apic_total)
        report("io_apic_total", g.io_apic_total, w.io_apic_total);
      if (g.override_total !== w.override_total)
        report("override_total", g.override_total, w.override_total);
      if (g.valid_tables !== w.valid_tables)
        report("valid_tables", g.valid_tables, w.valid_tables);
      if (g.entry_id !== w.entry_id)
        report("entry_id", g.entry_id, w.entry_id);
      if (g.entry_word_a !== w.entry_word_a)
        report("entry_word_a", g.entry_word_a, w.entry_word_a);
      if (g.entry_word_b !== w.entry_word_b)
        report("entry_word_b", g.entry_word_b, w.entry_word_b);
    endtask
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall;
  out_rsp_t out_rsp;

  acpi_table_stream_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp)
  );

  parser_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  bit hold_off;
  int idle_cycles;
  int requests_sent;
  byte unsigned tbl[$];

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_response(out_rsp);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // valid stays up after an accept; the next call either drives a new
  // request or drops valid in the same step
  task automatic send(in_req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(q);
    requests_sent++;
  endtask

  task automatic send_byte(bit [7:0] b, bit first);
    in_req_t q;
    q.opcode = OP_TABLE_BYTE;
    q.data_byte = b;
    q.first_byte = first;
    q.index = 6'($urandom);
    send(q);
  endtask

  task automatic send_read(bit [1:0] op, bit [5:0] idx);
    in_req_t q;
    q.opcode = op;
    q.data_byte = 8'($urandom);
    q.first_byte = 1'($urandom);
    q.index = idx;
    send(q);
  endtask

  task automatic push_le(int unsigned v, int n);
    for (int i = 0; i < n; i++) tbl.push_back(byte'(v >> (8 * i)));
  endtask

  // finishes a table in tbl: sets the signature, then fixes length and checksum if asked
  task automatic build_table(bit [31:0] sig, bit fix_sum, bit fix_len);
    byte unsigned s;
    int n;
    n = tbl.size();
    if (fix_len) for (int i = 0; i < 4; i++) tbl[4 + i] = byte'(n >> (8 * i));
    for (int i = 0; i < 4; i++) tbl[i] = byte'(sig >> (8 * i));
    if (fix_sum) begin
      tbl[9] = 0;
      s = 0;
      foreach (tbl[i]) s += tbl[i];
      tbl[9] = byte'(-s);
    end
  endtask

  task automatic start_header();
    tbl.delete();
    for (int i = 0; i < 36; i++) tbl.push_back(byte'($urandom));
  endtask

  task automatic add_madt_entries(int count);
    int t, len;
    for (int e = 0; e < count; e++) begin
      t = $urandom_range(5);
      case (t)
        0: len = ($urandom_range(9) == 0) ? $urandom_range(2, 7) : 8;
        1: len = ($urandom_range(9) == 0) ? $urandom_range(2, 11) : 12;
        2: len = ($urandom_range(9) == 0) ? $urandom_range(2, 9) : 10;
        5: len = ($urandom_range(9) == 0) ? $urandom_range(2, 11) : 12;
        default: len = $urandom_range(2, 16);
      endcase
      if (t == 3) t = ENT_LAPIC_OVR;
      if (t == 4) t = $urandom_range(6, 255);
      tbl.push_back(byte'(t));
      tbl.push_back(byte'(len));
      for (int i = 2; i < len; i++)
        tbl.push_back((t == 0 && i == 4) ? byte'($urandom | ($urandom_range(3) != 0)) :
                      byte'($urandom));
    end
    if ($urandom_range(9) == 0) begin
      tbl.push_back(8'h00);
      tbl.push_back(byte'($urandom_range(1)));
      tbl.push_back(byte'($urandom));
    end
  endtask

  task automatic send_table();
    foreach (tbl[i]) send_byte(tbl[i], i == 0);
  endtask

  task automatic rand_table();
    int pick;
    bit [31:0] sig;
    pick = $urandom_range(99);
    start_header();
    sig = (pick < 60) ? SIG_APIC : (pick < 80) ? SIG_HPET : 32'($urandom);
    if (sig == SIG_APIC) begin
      push_le($urandom, 8);
      add_madt_entries($urandom_range(0, 6));
    end else if (sig == SIG_HPET) begin
      for (int i = 0; i < $urandom_range(0, 24); i++) tbl.push_back(byte'($urandom));
    end else begin
      for (int i = 0; i < $urandom_range(0, 12); i++) tbl.push_back(byte'($urandom));
    end
    build_table(sig, $urandom_range(9) != 0, 1);
    // occasionally cut the length short so the last entry is truncated
    if ($urandom_range(9) == 0 && tbl.size() > 40) begin
      tbl[4] = byte'(tbl.size() - $urandom_range(1, 3));
      build_table(sig, 1, 0);
    end
    if ($urandom_range(19) == 0) begin
      // abandon part way, a new table will start
      for (int i = 0; i < $urandom_range(1, tbl.size() - 1); i++) send_byte(tbl[i], i == 0);
    end else begin
      send_table();
    end
  endtask

  // runs random traffic until about budget requests have gone in
  task automatic run_phase(int idle, int stall, int budget);
    int start;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    start = requests_sent;
    while (requests_sent - start < budget) begin
      case ($urandom_range(9))
        0, 1, 2: send_read(2'($urandom_range(1, 3)), 6'($urandom_range(0, 20)));
        3: send_read(2'($urandom_range(1, 3)), 6'($urandom));
        4: send_byte(8'($urandom), 1'b0);
        default: rand_table();
      endcase
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    requests_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reads before any table, stray byte, short length
    send_read(OP_READ_CPU, 6'd0);
    send_read(OP_READ_OVR, 6'd63);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h41, 1'b1); send_byte(8'h50, 1'b0); send_byte(8'h49, 1'b0);
    send_byte(8'h43, 1'b0); send_byte(8'h23, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    // valid MADT with one of each entry type
    start_header();
    push_le(32'hFEE0_0000, 4); push_le(0, 4);
    tbl.push_back(ENT_LAPIC); tbl.push_back(8); push_le(32'h0101_FF00, 4); push_le(1, 4);
    tbl.push_back(ENT_IOAPIC); tbl.push_back(12); push_le(32'h0000_0200, 4);
    push_le(32'hFEC0_0000, 4); push_le(0, 4);
    tbl.push_back(ENT_OVERRIDE); tbl.push_back(10); push_le(32'h0000_0000, 4);
    push_le(32'hFFFF_FFFF, 4); push_le(32'hFFFF, 2);
    tbl.push_back(ENT_LAPIC_OVR); tbl.push_back(12); push_le(0, 2);
    push_le(32'hFFFF_FFFF, 4); push_le(32'hFFFF_FFFF, 4);
    build_table(SIG_APIC, 1, 1);
    send_table();
    send_read(OP_READ_CPU, 6'd0);
    send_read(OP_READ_IOAPIC, 6'd0);
    send_read(OP_READ_OVR, 6'd0);
    send_read(OP_READ_IOAPIC, 6'd1);
    // HPET with address, bad checksum then good
    start_header();
    push_le(0, 8); push_le(32'hFED0_0000, 4); push_le(32'hFFFF_FFFF, 4);
    build_table(SIG_HPET, 0, 1);
    tbl[9] = tbl[9] + 1;
    send_table();
    build_table(SIG_HPET, 1, 0);
    send_table();

    run_phase(0, 0, 220);
    run_phase(85, 0, 150);
    run_phase(0, 85, 150);
    run_phase(27, 27, 150);

    // long hold-off on the receiver while requests keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      run_phase(0, 0, 30);
    join

    in_valid <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("sent %0d requests: %0d table results, %0d reads checked",
             requests_sent, sb.tables_done, sb.reads_done);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
